[rtl/grouped_bitmap_allocator_defines.svh]
// Assertion macros for the grouped bitmap allocator.
`ifndef GROUPED_BITMAP_ALLOCATOR_DEFINES_SVH
`define GROUPED_BITMAP_ALLOCATOR_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define GBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define GBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[rtl/gba_pkg.sv]
// Package with types, constants and codes of the grouped bitmap allocator.
`timescale 1ns / 1ps
package gba_pkg;
  localparam int MAX_GROUPS_DEF          = 8;
  localparam int MAX_ITEMS_PER_GROUP_DEF = 1024;
  localparam int WORD_BITS_DEF           = 64;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_MARK  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FREE   = 3'd1;
  localparam logic [2:0] ST_WAS_FREE  = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_WAS_USED  = 3'd4;

  localparam logic [1:0] REG_GROUP_COUNT = 2'd0;
  localparam logic [1:0] REG_ITEMS       = 2'd1;
  localparam logic [1:0] REG_BASE        = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [13:0] item_number;
  } in_item_t;

  typedef struct packed {
    logic [13:0] result_number;
    logic [2:0]  status;
    logic [2:0]  group_index;
    logic [10:0] group_free;
    logic [13:0] total_free;
  } out_item_t;
endpackage

[rtl/grouped_bitmap_allocator.sv]
// Top level of the grouped bitmap allocator.
`timescale 1ns / 1ps
// Grouped bitmap allocator.
// The input channel (in_valid/in_ready/in_data) takes one command per transfer:
// allocate the lowest free item, free a number or mark a number used. Every
// command but the unused code 3 yields one result transfer on out_valid/out_ready
// with the number, a status, the touched group and the free counts.
// The bitmap lives in a synchronous memory of one word per row with registered
// read data; per-group used counts sit in flip-flops.
// A free or mark splits the number into group and bit (one quotient bit
// per cycle, restoring division by the group size), then reads the word,
// modifies and writes it back, sums the free counts over the groups in use
// and loads the output register. An allocate reads one word per cycle from
// group 0 upward until a word with a free item turns up or every word of
// the groups in use has been read, then sums the free counts and loads the
// output register.
// One command is handled at a time: in_ready stays low until the result has
// been transferred, so a stalled receiver holds the block with its result
// waiting in the output register; the next command is taken in the cycle after
// the result transfer at the earliest. Reset (synchronous, rst_n low) restores
// the registers and then runs a clearing pass over all memory rows while
// in_ready is low. Configuration writes on cfg_we/cfg_index/cfg_data are taken
// any time and must only happen while the block is idle.
module grouped_bitmap_allocator
  import gba_pkg::*;
#(
  parameter int MAX_GROUPS          = MAX_GROUPS_DEF,
  parameter int MAX_ITEMS_PER_GROUP = MAX_ITEMS_PER_GROUP_DEF,
  parameter int WORD_BITS           = WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);
`include "grouped_bitmap_allocator_defines.svh"

  localparam int WB      = $clog2(WORD_BITS);
  localparam int WPG     = (MAX_ITEMS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH   = MAX_GROUPS * WPG;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int GW      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int WIW     = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int QB      = 14;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DIV   = 8'b0000_0100,
    S_SCAN  = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_MOD   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]  gcnt_r;
  logic [10:0] ipg_r;
  logic        base_r;

  // Saturated configuration.
  logic [3:0]  eff_gc;
  logic [10:0] eff_ipg;
  always_comb begin
    eff_gc  = (gcnt_r == 4'd0) ? 4'd1 : gcnt_r;
    if (32'(eff_gc) > MAX_GROUPS) eff_gc = 4'(MAX_GROUPS);
    eff_ipg = (ipg_r == 11'd0) ? 11'd1 : ipg_r;
    if (32'(eff_ipg) > MAX_ITEMS_PER_GROUP) eff_ipg = 11'(MAX_ITEMS_PER_GROUP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r <= 4'd1;
      ipg_r  <= 11'd1024;
      base_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUP_COUNT: gcnt_r <= cfg_data[3:0];
        REG_ITEMS:       ipg_r  <= cfg_data;
        REG_BASE:        base_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Bitmap memory.
  logic [WORD_BITS-1:0] mem [DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata_r;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  logic [10:0] used_r [MAX_GROUPS];

  logic [1:0]   cmd_r;
  logic [13:0]  num_r;
  logic [13:0]  rem_r;     // running remainder, then bit within group
  logic [QB-1:0] quo_r;
  logic [3:0]   step_r;
  logic [GW:0]    g_r;     // one bit wider so the scan can run past the last group
  logic [WIW-1:0] w_r;
  logic [AW-1:0]  addr_r;
  logic           pend_r;  // a read was issued last cycle in the scan
  logic [GW-1:0]  pg_r;
  logic [WIW-1:0] pw_r;
  logic [AW-1:0]  paddr_r;
  logic [WB-1:0]  bit_r;
  logic [2:0]     st_r;
  logic [GW:0]    sg_r;
  logic [13:0]    sum_r;
  out_item_t      out_r;
  logic           ovalid_r;

  assign in_ready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = out_r;

  wire in_fire  = in_valid && in_ready;

  // Restoring division step: num - base by items_per_group, one bit a cycle.
  logic [14:0] trial;
  assign trial = {rem_r, quo_r[QB-1]} - {4'd0, eff_ipg};

  // Lowest clear bit in the word read during the scan, masked to valid items.
  logic [WORD_BITS-1:0] freemask;
  logic [WB-1:0]        fidx;
  logic                 ffound;
  logic [16:0]          wbase;
  always_comb begin
    wbase = 17'(pw_r) * 17'(WORD_BITS);
    for (int k = 0; k < WORD_BITS; k++)
      freemask[k] = !mem_rdata_r[k] && ((wbase + 17'(k)) < 17'(eff_ipg));
    fidx = '0; ffound = 1'b0;
    for (int k = WORD_BITS - 1; k >= 0; k--)
      if (freemask[k]) begin fidx = WB'(k); ffound = 1'b1; end
  end

  logic [10:0] last_word;   // index of last word holding group items
  assign last_word = 11'((32'(eff_ipg) - 1) / WORD_BITS);

  // Word the scan requests this cycle, and the word that holds the bit of a
  // free or mark once the division is done.
  logic [AW-1:0] scan_addr, rd_addr;
  assign scan_addr = AW'(32'(g_r) * WPG + 32'(w_r));
  assign rd_addr   = AW'(32'(quo_r[GW-1:0]) * WPG + 32'(rem_r) / WORD_BITS);

  logic [GW-1:0] gsel;
  logic [10:0] gfree;
  assign gsel  = g_r[GW-1:0];
  assign gfree = (used_r[gsel] >= eff_ipg) ? 11'd0 : eff_ipg - used_r[gsel];

  logic [10:0] sfree;
  logic [GW-1:0] sgi;
  assign sgi   = sg_r[GW-1:0];
  assign sfree = (used_r[sgi] >= eff_ipg) ? 11'd0 : eff_ipg - used_r[sgi];

  logic bitval;
  assign bitval = mem_rdata_r[bit_r];

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = mem_rdata_r;
    mem_raddr = addr_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1; mem_wdata = '0;
        if (32'(addr_r) == DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_fire) begin
        if (in_data.cmd == CMD_ALLOC) state_nxt = S_SCAN;
        else if (in_data.cmd == CMD_FREE || in_data.cmd == CMD_MARK) state_nxt = S_DIV;
      end
      S_DIV: if (step_r == 4'(QB - 1)) state_nxt = S_RD;
      S_SCAN: begin
        mem_raddr = scan_addr;
        if (pend_r && ffound) begin
          mem_we = 1'b1; mem_waddr = paddr_r;
          mem_wdata = mem_rdata_r | (WORD_BITS'(1) << fidx);
          state_nxt = S_SUM;
        end else if (!pend_r && 32'(g_r) >= 32'(eff_gc)) begin
          state_nxt = S_SUM;
        end
      end
      S_RD: begin
        mem_raddr = rd_addr;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // Only a free of a set bit or a mark of a clear bit changes the word.
        if (st_r == ST_OK && ((cmd_r == CMD_FREE) == bitval)) begin
          mem_we = 1'b1;
          mem_wdata = mem_rdata_r ^ (WORD_BITS'(1) << bit_r);
        end
        state_nxt = S_SUM;
      end
      S_SUM: if (32'(sg_r) >= 32'(eff_gc) || 32'(sg_r) >= MAX_GROUPS) state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      addr_r   <= '0;
      ovalid_r <= 1'b0;
      pend_r   <= 1'b0;
      for (int k = 0; k < MAX_GROUPS; k++) used_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: addr_r <= addr_r + 1'b1;
        S_IDLE: if (in_fire) begin
          cmd_r  <= in_data.cmd;
          num_r  <= in_data.item_number;
          rem_r  <= '0;
          quo_r  <= in_data.item_number - 14'(base_r);
          step_r <= '0;
          g_r    <= '0;
          w_r    <= '0;
          addr_r <= '0;
          pend_r <= 1'b0;
          sg_r   <= '0;
          sum_r  <= '0;
        end
        S_DIV: begin
          step_r <= step_r + 1'b1;
          if (!trial[14]) begin
            rem_r <= trial[13:0];
            quo_r <= {quo_r[QB-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[12:0], quo_r[QB-1]};
            quo_r <= {quo_r[QB-2:0], 1'b0};
          end
          if (step_r == 4'(QB - 1)) begin
            // quotient/remainder known after this edge; range is checked in S_RD
          end
        end
        S_SCAN: begin
          if (pend_r && ffound) begin
            used_r[pg_r] <= used_r[pg_r] + 11'd1;
            g_r   <= {1'b0, pg_r};
            st_r  <= ST_OK;
            num_r <= 14'(32'(pg_r) * 32'(eff_ipg) + 32'(pw_r) * WORD_BITS
                         + 32'(fidx) + 32'(base_r));
            pend_r <= 1'b0;
          end else if (32'(g_r) >= 32'(eff_gc)) begin
            // Every word has been requested; the last read drains first.
            pend_r <= 1'b0;
            if (!pend_r) begin
              g_r <= '0; st_r <= ST_NO_FREE; num_r <= '0;
            end
          end else begin
            pend_r  <= 1'b1;
            pg_r    <= g_r[GW-1:0];
            pw_r    <= w_r;
            paddr_r <= scan_addr;
            if (32'(w_r) >= 32'(last_word)) begin
              w_r <= '0; g_r <= g_r + 1'b1;
            end else begin
              w_r <= w_r + 1'b1;
            end
          end
        end
        S_RD: begin
          g_r    <= {1'b0, quo_r[GW-1:0]};
          addr_r <= rd_addr;
          bit_r  <= rem_r[WB-1:0];
          if (num_r < 14'(base_r) || 32'(quo_r) >= 32'(eff_gc)) st_r <= ST_RANGE;
          else st_r <= ST_OK;
        end
        S_MOD: begin
          if (st_r != ST_RANGE) begin
            if (cmd_r == CMD_FREE) begin
              if (bitval) used_r[gsel] <= used_r[gsel] - 11'd1;
              else st_r <= ST_WAS_FREE;
            end else begin
              if (!bitval) used_r[gsel] <= used_r[gsel] + 11'd1;
              else st_r <= ST_WAS_USED;
            end
          end
        end
        S_SUM: begin
          if (32'(sg_r) < 32'(eff_gc) && 32'(sg_r) < MAX_GROUPS) begin
            sum_r <= sum_r + 14'(sfree);
            sg_r  <= sg_r + 1'b1;
          end
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          out_r.result_number <= num_r;
          out_r.status        <= (st_r == ST_RANGE && cmd_r != CMD_ALLOC) ? ST_RANGE : st_r;
          out_r.group_index   <= (st_r == ST_RANGE) ? 3'd0 : 3'(g_r);
          out_r.group_free    <= (st_r == ST_RANGE) ? 11'd0 : gfree;
          out_r.total_free    <= sum_r;
        end
        default: ;
      endcase
    end
  end

  `GBA_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE,
                  "in_ready outside idle")
  `GBA_ASSERT_NXT(a_out_after, clk, rst_n, state_r == S_OUT, out_valid,
                  "result not presented")
  `GBA_ASSERT_IMP(a_no_ready_busy, clk, rst_n, out_valid && !out_ready, !in_ready,
                  "accept while result waits")
endmodule

[verif/grouped_bitmap_allocator_tb.sv]
// Self-checking testbench for the grouped bitmap allocator.
`timescale 1ns / 1ps
module grouped_bitmap_allocator_tb;
  import gba_pkg::*;

  // Command code 3 is unused: the block drops it and sends no result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STORE_BITS = MAX_GROUPS_DEF * MAX_ITEMS_PER_GROUP_DEF;
  localparam int STALL_LIMIT = 20000;
  // Longest allocate scan reads 8 groups of 16 words; the settle wait covers
  // any command still in flight.
  localparam int SETTLE_CYCLES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_GROUP_COUNT;
  logic [10:0] cfg_data = '0;

  grouped_bitmap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the allocator: bitmap, per-group used counts and the
  // raw register values exactly as they were written.
  bit          used_map [STORE_BITS];
  logic [10:0] grp_used [MAX_GROUPS_DEF];
  logic [3:0]  shadow_groups;
  logic [10:0] shadow_items;
  logic        shadow_base;

  in_item_t    pending_cmds [$];
  out_item_t   expected_results [$];
  int          error_count = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;

  // Registers saturate before use, so zero and oversized values are legal.
  function automatic int groups_in_use();
    if (shadow_groups < 1) return 1;
    if (shadow_groups > MAX_GROUPS_DEF) return MAX_GROUPS_DEF;
    return shadow_groups;
  endfunction

  function automatic int group_size();
    if (shadow_items < 1) return 1;
    if (shadow_items > MAX_ITEMS_PER_GROUP_DEF) return MAX_ITEMS_PER_GROUP_DEF;
    return shadow_items;
  endfunction

  // Free count floors at zero: bits left past a shrunk group still count.
  function automatic int free_left(int g);
    if (grp_used[g] >= group_size()) return 0;
    return group_size() - grp_used[g];
  endfunction

  function automatic int free_overall();
    int sum;
    sum = 0;
    for (int g = 0; g < groups_in_use(); g++) sum += free_left(g);
    return sum;
  endfunction

  // Applies one command to the shadow state and works out its result.
  task automatic apply_command(input in_item_t it, output bit produces,
                               output out_item_t r);
    int gc, ipg, g, i, n, pos;
    bit found;
    gc = groups_in_use();
    ipg = group_size();
    produces = 1'b1;
    found = 1'b0;
    r = '0;
    if (it.cmd == CMD_UNUSED) begin
      produces = 1'b0;
    end else if (it.cmd == CMD_ALLOC) begin
      for (g = 0; g < gc && !found; g++) begin
        for (i = 0; i < ipg && !found; i++) begin
          pos = g * MAX_ITEMS_PER_GROUP_DEF + i;
          if (!used_map[pos]) begin
            used_map[pos] = 1'b1;
            grp_used[g] = grp_used[g] + 11'd1;
            found = 1'b1;
            r.result_number = 14'(g * ipg + i + int'(shadow_base));
            r.status = ST_OK;
            r.group_index = 3'(g);
            r.group_free = 11'(free_left(g));
          end
        end
      end
      if (!found) begin
        r.result_number = '0;
        r.status = ST_NO_FREE;
        r.group_index = '0;
        r.group_free = 11'(free_left(0));
      end
    end else begin
      r.result_number = it.item_number;
      n = int'(it.item_number) - int'(shadow_base);
      if (n < 0 || n / ipg >= gc) begin
        // Below the base or past the last group in use: nothing changes.
        r.status = ST_RANGE;
      end else begin
        g = n / ipg;
        i = n % ipg;
        pos = g * MAX_ITEMS_PER_GROUP_DEF + i;
        r.group_index = 3'(g);
        if (it.cmd == CMD_FREE) begin
          if (used_map[pos]) begin
            used_map[pos] = 1'b0;
            grp_used[g] = grp_used[g] - 11'd1;
            r.status = ST_OK;
          end else begin
            r.status = ST_WAS_FREE;
          end
        end else begin
          if (!used_map[pos]) begin
            used_map[pos] = 1'b1;
            grp_used[g] = grp_used[g] + 11'd1;
            r.status = ST_OK;
          end else begin
            r.status = ST_WAS_USED;
          end
        end
        r.group_free = 11'(free_left(g));
      end
    end
    r.total_free = 14'(free_overall());
  endtask

  // Sender: offers queued commands, idling at random unless in a steady
  // stretch. The prediction is made at the edge where the transfer happens.
  always @(posedge clk) begin
    bit produces;
    out_item_t r;
    bit accepted;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        apply_command(in_data, produces, r);
        if (produces) expected_results.push_back(r);
      end
      if (!in_valid || accepted) begin
        if (pending_cmds.size() > 0 && (steady || $urandom_range(99) >= 31)) begin
          in_valid <= 1'b1;
          in_data <= pending_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer against the oldest expectation.
  // After 400 results it holds off for a long stretch so the block backs up.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_seen == 400) hold_left = 300;
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result num=%0d st=%0d grp=%0d gfree=%0d tfree=%0d",
                   $time, out_data.result_number, out_data.status,
                   out_data.group_index, out_data.group_free, out_data.total_free);
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            error_count++;
            $display("%0t: expected num=%0d st=%0d grp=%0d gfree=%0d tfree=%0d",
                     $time, want.result_number, want.status, want.group_index,
                     want.group_free, want.total_free);
            $display("%0t: actual   num=%0d st=%0d grp=%0d gfree=%0d tfree=%0d",
                     $time, out_data.result_number, out_data.status,
                     out_data.group_index, out_data.group_free, out_data.total_free);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || $urandom_range(99) >= 31;
      end
    end
  end

  // Watchdog: ends the run if no transfer happens on either channel for
  // too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Waits until every command went through and every result came back,
  // then lets a possibly silent last command drain.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == REG_GROUP_COUNT) shadow_groups = value[3:0];
    else if (idx == REG_ITEMS) shadow_items = value;
    else shadow_base = value[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_cmd(input logic [1:0] c, input int num);
    in_item_t it;
    it.cmd = c;
    it.item_number = num[13:0];
    pending_cmds.push_back(it);
  endtask

  // Mostly numbers inside the groups in use, some on the edges and some
  // anywhere in the 14-bit field.
  function automatic int pick_number();
    int span, roll;
    span = groups_in_use() * group_size();
    roll = $urandom_range(99);
    if (roll < 70) return shadow_base + $urandom_range(span - 1);
    if (roll < 85) return shadow_base + span - 1 + $urandom_range(2);
    if (roll < 88) return 0;
    return $urandom_range(16383);
  endfunction

  task automatic queue_random(input int count);
    int roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 40) queue_cmd(CMD_ALLOC, $urandom_range(16383));
      else if (roll < 68) queue_cmd(CMD_FREE, pick_number());
      else if (roll < 97) queue_cmd(CMD_MARK, pick_number());
      else queue_cmd(CMD_UNUSED, $urandom_range(16383));
    end
  endtask

  initial begin
    for (int k = 0; k < STORE_BITS; k++) used_map[k] = 1'b0;
    for (int g = 0; g < MAX_GROUPS_DEF; g++) grp_used[g] = '0;
    shadow_groups = 4'd1;
    shadow_items = 11'd1024;
    shadow_base = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at reset settings: one group of 1024 items, base zero.
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_FREE, 0);
    queue_cmd(CMD_FREE, 0);
    queue_cmd(CMD_MARK, 5);
    queue_cmd(CMD_MARK, 5);
    queue_cmd(CMD_MARK, 1023);
    queue_cmd(CMD_FREE, 1024);
    queue_cmd(CMD_FREE, 16383);
    queue_cmd(CMD_UNUSED, 0);
    queue_cmd(CMD_ALLOC, 16383);
    wait_drained();

    // A single one-item group with base one: fill it, then nothing is free,
    // and a number below the base is out of range.
    write_reg(REG_GROUP_COUNT, 11'd1);
    write_reg(REG_ITEMS, 11'd1);
    write_reg(REG_BASE, 11'd1);
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_ALLOC, 0);
    queue_cmd(CMD_FREE, 0);
    queue_cmd(CMD_FREE, 1);
    queue_cmd(CMD_FREE, 1);
    queue_cmd(CMD_MARK, 1);
    queue_cmd(CMD_MARK, 2);
    queue_cmd(CMD_ALLOC, 0);
    wait_drained();

    // Random phases over several settings, the saturating extremes among
    // them. One phase runs with no idling on either side.
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin
          write_reg(REG_GROUP_COUNT, 11'd8);
          write_reg(REG_ITEMS, 11'd1024);
          write_reg(REG_BASE, 11'd0);
        end
        1: begin
          write_reg(REG_GROUP_COUNT, 11'd15);
          write_reg(REG_ITEMS, 11'd2047);
          write_reg(REG_BASE, 11'd1);
        end
        2: begin
          write_reg(REG_GROUP_COUNT, 11'd0);
          write_reg(REG_ITEMS, 11'd0);
          write_reg(REG_BASE, 11'd0);
        end
        3: begin
          write_reg(REG_GROUP_COUNT, 11'd2);
          write_reg(REG_ITEMS, 11'd64);
          write_reg(REG_BASE, 11'd1);
        end
        4: begin
          write_reg(REG_GROUP_COUNT, 11'd8);
          write_reg(REG_ITEMS, 11'd1);
          write_reg(REG_BASE, 11'd0);
        end
        default: begin
          write_reg(REG_GROUP_COUNT, 11'($urandom_range(1, 8)));
          write_reg(REG_ITEMS, 11'($urandom_range(1, 200)));
          write_reg(REG_BASE, 11'($urandom_range(1)));
        end
      endcase
      steady = (p == 5);
      queue_random(108);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
